// ----- hdl/mra_pkg.sv -----
// shared types, constants and codes for the memory reservation arbiter
`timescale 1ns / 1ps

package mra_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam int SIZE_W     = 48;
    localparam int TAG_W      = 8;
    localparam int ORDER_W    = 32;
    localparam int TICK_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPILL_EN = CFG_IDX_W'(1);

    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = TICK_W'(1000);
    localparam logic              SPILL_EN_RESET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EVAL,
        ST_RESULT
    } state_t;

    // what a table scan is looking for
    typedef enum logic [1:0] {
        OP_FREE,
        OP_FIT,
        OP_ANY,
        OP_FORCE
    } op_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        size;
        logic signed [SIZE_W-1:0] delta;
        logic [ORDER_W-1:0]       order;
        logic [TAG_W-1:0]         tag;
    } entry_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        size;
        logic signed [SIZE_W-1:0] delta;
        logic [ORDER_W-1:0]       age;
    } key_t;

    typedef struct packed {
        logic              grant_valid;
        logic [TAG_W-1:0]  grant_tag;
        logic [SIZE_W-1:0] grant_bytes;
        logic              grant_forced;
        logic              spill_valid;
        logic              spill_blocking;
        logic [SIZE_W-1:0] spill_bytes;
        logic              rejected;
    } res_t;

endpackage

// ----- hdl/mra_rank.sv -----
// shared ranking comparator: does the candidate entry rank before the current best
`timescale 1ns / 1ps

module mra_rank
    import mra_pkg::*;
(
    input  key_t cand,
    input  key_t best,
    input  logic size_first,
    output logic ahead
);

    logic size_lt;
    logic size_eq;
    logic delta_lt;
    logic delta_eq;
    logic older;

    assign size_lt  = cand.size < best.size;
    assign size_eq  = cand.size == best.size;
    assign delta_lt = cand.delta < best.delta;
    assign delta_eq = cand.delta == best.delta;
    assign older    = cand.age > best.age;

    always_comb
    begin
        if (size_first)
        begin
            if (!size_eq)
                ahead = size_lt;
            else if (!delta_eq)
                ahead = delta_lt;
            else
                ahead = older;
        end
        else
        begin
            if (!delta_eq)
                ahead = delta_lt;
            else if (!size_eq)
                ahead = size_lt;
            else
                ahead = older;
        end
    end

endmodule

// ----- hdl/mra_table.sv -----
// pending request table: entry memory with registered read and per-entry valid bits
`timescale 1ns / 1ps

module mra_table
    import mra_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_entry,
    output logic             rd_valid,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_entry,
    input  logic             clr_en,
    input  logic [IDX_W-1:0] clr_addr
);

    entry_t entry_mem [DEPTH];

    entry_t             rd_entry_reg;
    logic               rd_valid_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
            valid_next[wr_addr] = 1'b1;
        if (clr_en)
            valid_next[clr_addr] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= wr_entry;
        rd_entry_reg <= entry_mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ----- hdl/memory_reservation_arbiter_core.sv -----
// top level of the memory reservation arbiter: sequencer, scan datapath and ports
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    mode, req_size, net_delta, req_tag, available
// out       output     out_valid / out_ready  grant_*, spill_*, rejected, pending_count
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a request that fits, a rejected request and a tick on an empty table skip the table scan
// a request that waits or a tick with waiters scans the table once
// a tick where nothing fits and no spill was tried yet scans twice
// the scan length is set by the single table read port and the one shared ranking compare
// in_ready is high only while idle; a finished result waits in the output register
// reset clears the valid bits, counters and the output valid flag; cfg_ready is always high
`timescale 1ns / 1ps

module memory_reservation_arbiter_core
    import mra_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic [SIZE_W-1:0]       req_size,
    input  logic signed [SIZE_W-1:0] net_delta,
    input  logic [TAG_W-1:0]        req_tag,
    input  logic [SIZE_W-1:0]       available,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    grant_valid,
    output logic [TAG_W-1:0]        grant_tag,
    output logic [SIZE_W-1:0]       grant_bytes,
    output logic                    grant_forced,
    output logic                    spill_valid,
    output logic                    spill_blocking,
    output logic [SIZE_W-1:0]       spill_bytes,
    output logic                    rejected,
    output logic [CNT_W-1:0]        pending_count,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // control state
    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [TICK_W-1:0]      timeout_reg, timeout_next;
    logic                   spill_en_reg, spill_en_next;
    logic [ORDER_W-1:0]     arrival_reg, arrival_next;
    logic [TICK_W-1:0]      ticks_reg, ticks_next;
    logic                   spill_tried_reg, spill_tried_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W:0]         issue_reg, issue_next;
    logic                   dvld_reg, dvld_next;
    logic                   found_reg, found_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic                   mode_reg, mode_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic signed [SIZE_W-1:0] delta_reg, delta_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [SIZE_W-1:0]      avail_reg, avail_next;
    logic [IDX_W-1:0]       didx_reg, didx_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    key_t                   best_key_reg, best_key_next;
    logic [TAG_W-1:0]       best_tag_reg, best_tag_next;
    res_t                   res_reg, res_next;
    res_t                   out_res_reg, out_res_next;
    logic [CNT_W-1:0]       out_count_reg, out_count_next;

    // table and compare unit
    logic [IDX_W-1:0]       rd_addr;
    entry_t                 rd_entry;
    logic                   rd_valid;
    logic                   wr_en;
    entry_t                 wr_entry;
    logic                   clr_en;
    key_t                   cand_key;
    logic                   cand_before;
    logic                   cand_fit;
    logic                   scan_done;
    logic                   in_fire;
    logic                   out_free;

    mra_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (best_idx_reg),
        .wr_entry (wr_entry),
        .clr_en   (clr_en),
        .clr_addr (best_idx_reg)
    );

    assign cand_key.size  = rd_entry.size;
    assign cand_key.delta = rd_entry.delta;
    assign cand_key.age   = arrival_reg - rd_entry.order;

    mra_rank u_rank (
        .cand       (cand_key),
        .best       (best_key_reg),
        .size_first (op_reg == OP_FORCE),
        .ahead      (cand_before)
    );

    assign cand_fit  = rd_entry.size <= avail_reg;
    assign scan_done = (issue_reg == (IDX_W + 1)'(DEPTH)) && !dvld_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign rd_addr   = issue_reg[IDX_W-1:0];

    assign wr_entry.size  = size_reg;
    assign wr_entry.delta = delta_reg;
    assign wr_entry.order = arrival_reg;
    assign wr_entry.tag   = tag_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (mode_reg)
                    state_next = (count_reg == '0) ? ST_RESULT : ST_SCAN;
                else if (size_reg <= avail_reg || count_reg == CNT_W'(DEPTH))
                    state_next = ST_RESULT;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (op_reg == OP_FIT && !found_reg && !spill_tried_reg)
                    state_next = ST_SCAN;
                else
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next          = op_reg;
        timeout_next     = timeout_reg;
        spill_en_next    = spill_en_reg;
        arrival_next     = arrival_reg;
        ticks_next       = ticks_reg;
        spill_tried_next = spill_tried_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;
        dvld_next        = 1'b0;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        size_next        = size_reg;
        delta_next       = delta_reg;
        tag_next         = tag_reg;
        avail_next       = avail_reg;
        didx_next        = didx_reg;
        best_idx_next    = best_idx_reg;
        best_key_next    = best_key_reg;
        best_tag_next    = best_tag_reg;
        res_next         = res_reg;
        out_res_next     = out_res_reg;
        out_count_next   = out_count_reg;
        wr_en            = 1'b0;
        clr_en           = 1'b0;

        if (cfg_valid)
        begin
            if (cfg_index == REG_TIMEOUT)
                timeout_next = cfg_data;
            else if (cfg_index == REG_SPILL_EN)
                spill_en_next = cfg_data[0];
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next  = mode;
                    size_next  = req_size;
                    delta_next = net_delta;
                    tag_next   = req_tag;
                    avail_next = available;
                    // a tick with waiters advances the timer, saturating
                    if (mode && count_reg != '0 && ticks_reg != '1)
                        ticks_next = ticks_reg + TICK_W'(1);
                end
            end
            ST_DECIDE:
            begin
                res_next   = '0;
                issue_next = '0;
                found_next = 1'b0;
                if (mode_reg)
                begin
                    if (count_reg == '0)
                    begin
                        ticks_next       = '0;
                        spill_tried_next = 1'b0;
                    end
                    else if (ticks_reg > timeout_reg)
                        op_next = OP_FORCE;
                    else
                        op_next = OP_FIT;
                end
                else if (size_reg <= avail_reg)
                begin
                    res_next.grant_valid = 1'b1;
                    res_next.grant_tag   = tag_reg;
                    res_next.grant_bytes = size_reg;
                end
                else if (count_reg == CNT_W'(DEPTH))
                    res_next.rejected = 1'b1;
                else
                    op_next = OP_FREE;
            end
            ST_SCAN:
            begin
                if (issue_reg != (IDX_W + 1)'(DEPTH))
                begin
                    issue_next = issue_reg + (IDX_W + 1)'(1);
                    dvld_next  = 1'b1;
                    didx_next  = issue_reg[IDX_W-1:0];
                end
                if (dvld_reg)
                begin
                    if (op_reg == OP_FREE)
                    begin
                        // first free slot wins
                        if (!found_reg && !rd_valid)
                        begin
                            found_next    = 1'b1;
                            best_idx_next = didx_reg;
                        end
                    end
                    else if (rd_valid && (op_reg != OP_FIT || cand_fit)
                             && (!found_reg || cand_before))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = didx_reg;
                        best_key_next = cand_key;
                        best_tag_next = rd_entry.tag;
                    end
                end
            end
            ST_EVAL:
            begin
                case (op_reg)
                    OP_FREE:
                    begin
                        wr_en = 1'b1;
                        if (count_reg == '0)
                        begin
                            ticks_next       = '0;
                            spill_tried_next = 1'b0;
                        end
                        arrival_next = arrival_reg + ORDER_W'(1);
                        count_next   = count_reg + CNT_W'(1);
                    end
                    OP_FORCE:
                    begin
                        if (found_reg)
                        begin
                            clr_en                = 1'b1;
                            count_next            = count_reg - CNT_W'(1);
                            res_next.grant_valid  = 1'b1;
                            res_next.grant_forced = 1'b1;
                            res_next.grant_tag    = best_tag_reg;
                            res_next.grant_bytes  = (best_key_reg.size <= avail_reg)
                                                    ? best_key_reg.size : '0;
                            if (spill_en_reg)
                            begin
                                res_next.spill_valid    = 1'b1;
                                res_next.spill_blocking = 1'b1;
                                res_next.spill_bytes    = best_key_reg.size;
                            end
                        end
                        ticks_next       = '0;
                        spill_tried_next = 1'b0;
                    end
                    OP_FIT:
                    begin
                        if (found_reg)
                        begin
                            clr_en               = 1'b1;
                            count_next           = count_reg - CNT_W'(1);
                            res_next.grant_valid = 1'b1;
                            res_next.grant_tag   = best_tag_reg;
                            res_next.grant_bytes = best_key_reg.size;
                            ticks_next           = '0;
                            spill_tried_next     = 1'b0;
                        end
                        else if (!spill_tried_reg)
                        begin
                            // nothing fits: second pass for the spill sizing
                            op_next    = OP_ANY;
                            issue_next = '0;
                            found_next = 1'b0;
                        end
                    end
                    OP_ANY:
                    begin
                        if (found_reg && spill_en_reg)
                        begin
                            res_next.spill_valid = 1'b1;
                            res_next.spill_bytes = best_key_reg.size;
                        end
                        spill_tried_next = 1'b1;
                    end
                    default:
                    begin
                        op_next = OP_FIT;
                    end
                endcase
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_count_next = count_reg;
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_FIT;
            timeout_reg     <= TIMEOUT_RESET;
            spill_en_reg    <= SPILL_EN_RESET;
            arrival_reg     <= '0;
            ticks_reg       <= '0;
            spill_tried_reg <= 1'b0;
            count_reg       <= '0;
            issue_reg       <= '0;
            dvld_reg        <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            timeout_reg     <= timeout_next;
            spill_en_reg    <= spill_en_next;
            arrival_reg     <= arrival_next;
            ticks_reg       <= ticks_next;
            spill_tried_reg <= spill_tried_next;
            count_reg       <= count_next;
            issue_reg       <= issue_next;
            dvld_reg        <= dvld_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        size_reg      <= size_next;
        delta_reg     <= delta_next;
        tag_reg       <= tag_next;
        avail_reg     <= avail_next;
        didx_reg      <= didx_next;
        best_idx_reg  <= best_idx_next;
        best_key_reg  <= best_key_next;
        best_tag_reg  <= best_tag_next;
        res_reg       <= res_next;
        out_res_reg   <= out_res_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid      = out_valid_reg;
    assign grant_valid    = out_res_reg.grant_valid;
    assign grant_tag      = out_res_reg.grant_tag;
    assign grant_bytes    = out_res_reg.grant_bytes;
    assign grant_forced   = out_res_reg.grant_forced;
    assign spill_valid    = out_res_reg.spill_valid;
    assign spill_blocking = out_res_reg.spill_blocking;
    assign spill_bytes    = out_res_reg.spill_bytes;
    assign rejected       = out_res_reg.rejected;
    assign pending_count  = out_count_reg;

endmodule
